// ----- rtl/hcl_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hcl_pkg
// Shared types, character codes and the header name table for the
// content-length parser.
// ----------------------------------------------------------------------------
package hcl_pkg;

    localparam logic [7:0] CHAR_TAB   = 8'h09;
    localparam logic [7:0] CHAR_LF    = 8'h0A;
    localparam logic [7:0] CHAR_CR    = 8'h0D;
    localparam logic [7:0] CHAR_SPACE = 8'h20;
    localparam logic [7:0] CHAR_PLUS  = 8'h2B;
    localparam logic [7:0] CHAR_MINUS = 8'h2D;
    localparam logic [7:0] CHAR_ZERO  = 8'h30;
    localparam logic [7:0] CHAR_NINE  = 8'h39;
    localparam logic [7:0] CHAR_COLON = 8'h3A;

    localparam logic [3:0]  NAME_LEN      = 4'd14;
    localparam logic [3:0]  LINE_POS_MAX  = 4'd15;
    localparam logic [31:0] ACC_CAP       = 32'h8000_0000;
    localparam logic [31:0] POS_MAX       = 32'h7FFF_FFFF;
    localparam logic [31:0] FOUND_NONE    = 32'hFFFF_FFFF;
    localparam logic [30:0] DEFAULT_RESET = 31'd1000000;

    typedef enum logic [3:0] {
        PH_SKIP   = 4'b0001,
        PH_SIGN   = 4'b0010,
        PH_DIGITS = 4'b0100,
        PH_DONE   = 4'b1000
    } t_num_phase;

    typedef struct packed {
        t_num_phase  phase;
        logic        negative;
        logic [31:0] acc;
        logic        clamped;
    } t_num_state;

    typedef struct packed {
        logic [31:0] value;
        logic        clamped;
    } t_commit;

    localparam t_num_state NUM_RESET = '{
        phase: PH_SKIP, negative: 1'b0, acc: 32'd0, clamped: 1'b0
    };

    // "Content-Length", one character per line position
    function automatic logic [7:0] name_char(input logic [3:0] pos);
        logic [7:0] c;
        unique case (pos)
            4'd0:    c = 8'h43; // C
            4'd1:    c = 8'h6F; // o
            4'd2:    c = 8'h6E; // n
            4'd3:    c = 8'h74; // t
            4'd4:    c = 8'h65; // e
            4'd5:    c = 8'h6E; // n
            4'd6:    c = 8'h74; // t
            4'd7:    c = 8'h2D; // -
            4'd8:    c = 8'h4C; // L
            4'd9:    c = 8'h65; // e
            4'd10:   c = 8'h6E; // n
            4'd11:   c = 8'h67; // g
            4'd12:   c = 8'h74; // t
            4'd13:   c = 8'h68; // h
            default: c = 8'h00;
        endcase
        return c;
    endfunction

endpackage

// ----- rtl/hcl_value_decoder.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hcl_value_decoder
// One step of the atoi-style value decoder: whitespace skip, sign, digits
// with saturation of the magnitude at 2^31.
// ----------------------------------------------------------------------------
module hcl_value_decoder
    import hcl_pkg::*;
(
    input  t_num_state i_state,
    input  logic [7:0] i_byte,
    output t_num_state o_state
);

    logic        is_digit;
    logic        is_space;
    logic [3:0]  digit;
    logic [34:0] times_ten;
    logic        over_cap;
    t_num_state  added;

    assign is_digit = (i_byte >= CHAR_ZERO) && (i_byte <= CHAR_NINE);
    assign is_space = (i_byte == CHAR_SPACE) || ((i_byte >= CHAR_TAB) && (i_byte <= CHAR_CR));
    assign digit    = 4'(i_byte - CHAR_ZERO);

    // acc * 10 + d as shift-add
    assign times_ten = {i_state.acc, 3'b000} + {2'b00, i_state.acc, 1'b0}
                     + {31'd0, digit};
    assign over_cap  = times_ten > {3'b000, ACC_CAP};

    always_comb begin
        added = i_state;
        added.phase = PH_DIGITS;
        if (!i_state.clamped) begin
            if (over_cap) begin
                added.acc     = ACC_CAP;
                added.clamped = 1'b1;
            end else begin
                added.acc = times_ten[31:0];
            end
        end
    end

    always_comb begin
        o_state = i_state;
        unique case (i_state.phase)
            PH_SKIP: begin
                priority if (is_space) begin
                    o_state = i_state;
                end else if (i_byte == CHAR_PLUS) begin
                    o_state.phase = PH_SIGN;
                end else if (i_byte == CHAR_MINUS) begin
                    o_state.phase    = PH_SIGN;
                    o_state.negative = 1'b1;
                end else if (is_digit) begin
                    o_state = added;
                end else begin
                    o_state.phase = PH_DONE;
                end
            end
            PH_SIGN, PH_DIGITS: begin
                if (is_digit) begin
                    o_state = added;
                end else begin
                    o_state.phase = PH_DONE;
                end
            end
            PH_DONE: begin
                o_state = i_state;
            end
            default: begin
                o_state = i_state;
            end
        endcase
    end

endmodule

// ----- rtl/hcl_commit.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hcl_commit
// Turns a decoded sign and magnitude into a signed 32-bit value with
// clamping at the end of a matching header line.
// ----------------------------------------------------------------------------
module hcl_commit
    import hcl_pkg::*;
(
    input  t_num_state i_state,
    output t_commit    o_commit
);

    always_comb begin
        if (i_state.negative) begin
            if (i_state.clamped) begin
                o_commit.value   = ACC_CAP;
                o_commit.clamped = 1'b1;
            end else begin
                o_commit.value   = 32'd0 - i_state.acc;
                o_commit.clamped = 1'b0;
            end
        end else if (i_state.acc > POS_MAX) begin
            o_commit.value   = POS_MAX;
            o_commit.clamped = 1'b1;
        end else begin
            o_commit.value   = i_state.acc;
            o_commit.clamped = 1'b0;
        end
    end

endmodule

// ----- rtl/http_header_content_length_parser.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// http_header_content_length_parser
// Streaming parser of an HTTP response head that reports its Content-Length.
// ----------------------------------------------------------------------------
// Takes one byte of the response head per cycle, with no gaps needed between
// items. A byte passes from the input register through the line and value logic
// into the state registers, and the LF ending the head loads the result into the
// output register. The only stall is a full output register while the master
// side holds m_axis_tready low. The result reports the last exact
// "Content-Length" value (atoi rules, saturated to 32 bits) or the default
// length register when none was usable, plus the header count, saturating at
// MAX_HEADERS (and at 255). The default length must be written while idle.
module http_header_content_length_parser
    import hcl_pkg::*;
#(
    parameter int MAX_HEADERS = 128
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_wen,
    input  logic [30:0] i_cfg_wdata,   // default_length
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,  // [7:0] data_byte
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // [31:0] reported_length, [32] length_found, [40:33] header_count,
    // [41] value_saturated, [47:42] zero
    output logic [47:0] m_axis_tdata
);

    localparam logic [7:0] COUNT_CAP = (MAX_HEADERS < 255) ? 8'(MAX_HEADERS) : 8'd255;

    logic [30:0] r_default_length;
    logic        r_in_valid;
    logic [7:0]  r_in_byte;
    logic        advance;

    logic        r_on_status;
    logic [3:0]  r_line_pos;
    logic        r_first_ends;
    logic        r_colon_seen;
    logic        r_name_match;
    logic        r_prev_cr;
    t_num_state  r_num;
    logic [31:0] r_found_value;
    logic        r_found_clamped;
    logic [7:0]  r_lines;

    logic        n_on_status;
    logic [3:0]  n_line_pos;
    logic        n_first_ends;
    logic        n_colon_seen;
    logic        n_name_match;
    logic        n_prev_cr;
    t_num_state  n_num;
    logic [31:0] n_found_value;
    logic        n_found_clamped;
    logic [7:0]  n_lines;

    logic        r_out_valid;
    logic [31:0] r_out_length;
    logic        r_out_found;
    logic [7:0]  r_out_count;
    logic        r_out_sat;

    t_num_state  dec_num;
    t_commit     commit;
    logic        line_end;
    logic        head_end;

    hcl_value_decoder u_value_decoder (
        .i_state (r_num),
        .i_byte  (r_in_byte),
        .o_state (dec_num)
    );

    hcl_commit u_commit (
        .i_state  (r_num),
        .o_commit (commit)
    );

    assign advance       = r_in_valid && (!r_out_valid || m_axis_tready);
    assign s_axis_tready = !r_in_valid || advance;
    assign line_end      = (r_in_byte == CHAR_LF) && r_prev_cr;
    assign head_end      = line_end && (r_first_ends || (r_line_pos == 4'd1));

    always_comb begin
        n_on_status     = r_on_status;
        n_line_pos      = r_line_pos;
        n_first_ends    = r_first_ends;
        n_colon_seen    = r_colon_seen;
        n_name_match    = r_name_match;
        n_prev_cr       = r_prev_cr;
        n_num           = r_num;
        n_found_value   = r_found_value;
        n_found_clamped = r_found_clamped;
        n_lines         = r_lines;
        if (line_end) begin
            // both cases start a fresh line
            n_line_pos   = 4'd0;
            n_first_ends = 1'b0;
            n_colon_seen = 1'b0;
            n_name_match = 1'b1;
            n_num        = NUM_RESET;
            n_prev_cr    = 1'b0;
            if (head_end) begin
                n_on_status     = 1'b1;
                n_found_value   = FOUND_NONE;
                n_found_clamped = 1'b0;
                n_lines         = 8'd0;
            end else begin
                if (!r_on_status) begin
                    if (r_lines < COUNT_CAP) begin
                        n_lines = r_lines + 8'd1;
                    end
                    if (r_name_match) begin
                        n_found_value   = commit.value;
                        n_found_clamped = commit.clamped;
                    end
                end
                n_on_status = 1'b0;
            end
        end else begin
            priority if ((r_in_byte == CHAR_COLON) && !r_colon_seen) begin
                if (r_line_pos == 4'd0) begin
                    n_first_ends = 1'b1;
                end
                if (r_line_pos != NAME_LEN) begin
                    n_name_match = 1'b0;
                end
                n_colon_seen = 1'b1;
            end else if (!r_colon_seen) begin
                if (r_line_pos < NAME_LEN) begin
                    if (r_in_byte != name_char(r_line_pos)) begin
                        n_name_match = 1'b0;
                    end
                end else if (!((r_line_pos == NAME_LEN) && (r_in_byte == CHAR_CR))) begin
                    n_name_match = 1'b0;
                end
            end else begin
                n_num = dec_num;
            end
            if (r_line_pos < LINE_POS_MAX) begin
                n_line_pos = r_line_pos + 4'd1;
            end
            n_prev_cr = (r_in_byte == CHAR_CR);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_default_length <= DEFAULT_RESET;
        end else if (i_cfg_wen) begin
            r_default_length <= i_cfg_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_axis_tvalid && s_axis_tready) begin
            r_in_valid <= 1'b1;
        end else if (advance) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tvalid && s_axis_tready) begin
            r_in_byte <= s_axis_tdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_on_status     <= 1'b1;
            r_line_pos      <= 4'd0;
            r_first_ends    <= 1'b0;
            r_colon_seen    <= 1'b0;
            r_name_match    <= 1'b1;
            r_prev_cr       <= 1'b0;
            r_num           <= NUM_RESET;
            r_found_value   <= FOUND_NONE;
            r_found_clamped <= 1'b0;
            r_lines         <= 8'd0;
        end else if (advance) begin
            r_on_status     <= n_on_status;
            r_line_pos      <= n_line_pos;
            r_first_ends    <= n_first_ends;
            r_colon_seen    <= n_colon_seen;
            r_name_match    <= n_name_match;
            r_prev_cr       <= n_prev_cr;
            r_num           <= n_num;
            r_found_value   <= n_found_value;
            r_found_clamped <= n_found_clamped;
            r_lines         <= n_lines;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance && head_end) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance && head_end) begin
            if (r_found_value == FOUND_NONE) begin
                r_out_length <= {1'b0, r_default_length};
                r_out_found  <= 1'b0;
                r_out_sat    <= 1'b0;
            end else begin
                r_out_length <= r_found_value;
                r_out_found  <= 1'b1;
                r_out_sat    <= r_found_clamped;
            end
            r_out_count <= r_lines;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {6'd0, r_out_sat, r_out_count, r_out_found, r_out_length};

    // a default length never carries the saturation flag
    a_sat_needs_found: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && !r_out_found |-> !r_out_sat)
        else $error("saturation flag set without a decoded length");

    a_count_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_lines <= COUNT_CAP)
        else $error("header count beyond cap");

    // end of head restarts the message
    a_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        advance && head_end |=> r_on_status && (r_lines == 8'd0) && !r_prev_cr
                                && (r_found_value == FOUND_NONE))
        else $error("message state not cleared after result");

    a_colon_pos: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_colon_seen |-> (r_line_pos != 4'd0))
        else $error("colon seen at line position zero");

endmodule

// ----- sim/tb_http_header_content_length_parser.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_http_header_content_length_parser
// Streams HTTP response heads into the parser byte by byte and checks every
// result item against a cycle-free predictor of the header and value logic.
// Covers directed corner cases under a long output stall, a header count
// overflow and randomized heads under the idling phases and several default
// lengths.
// ----------------------------------------------------------------------------
module tb_http_header_content_length_parser
    import hcl_pkg::*;
();

    localparam int MAX_HEADERS  = 128;
    localparam int HEADER_CAP   = (MAX_HEADERS < 255) ? MAX_HEADERS : 255;
    localparam int HOLD_CYCLES  = 300;
    localparam int DRAIN_CYCLES = 20;
    localparam int PHASE_BYTES  = 40;
    localparam logic [8*14-1:0] CL_NAME = "Content-Length";

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_cfg_wen = 1'b0;
    logic [30:0] i_cfg_wdata = '0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata = '0;   // [7:0] data_byte
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    // [31:0] reported_length, [32] length_found, [40:33] header_count,
    // [41] value_saturated, [47:42] zero
    logic [47:0] m_axis_tdata;

    int   send_idle_pct = 0;
    int   recv_stall_pct = 0;
    logic hold_off = 1'b0;
    bit   hold_go = 1'b0;
    logic [7:0] msg_bytes[$];

    class length_scoreboard;
        logic [30:0] default_len;
        bit          on_status;
        logic [3:0]  line_pos;
        bit          first_ends;
        bit          colon_seen;
        bit          name_match;
        bit          prev_cr;
        t_num_phase  num_phase;
        bit          negative;
        logic [31:0] acc;
        bit          acc_clamped;
        logic [31:0] found;
        bit          found_clamped;
        logic [7:0]  lines;
        logic [47:0] expected_results[$];
        int          errors;

        function new();
            default_len = DEFAULT_RESET;
            errors = 0;
            clear_message();
        endfunction

        function void clear_line();
            line_pos = '0;
            first_ends = 0;
            colon_seen = 0;
            name_match = 1;
            num_phase = PH_SKIP;
            negative = 0;
            acc = '0;
            acc_clamped = 0;
        endfunction

        function void clear_message();
            clear_line();
            on_status = 1;
            prev_cr = 0;
            found = FOUND_NONE;
            found_clamped = 0;
            lines = '0;
        endfunction

        function void add_digit(logic [7:0] d);
            logic [63:0] t;
            if (acc_clamped) return;
            t = {32'd0, acc} * 64'd10 + {56'd0, d};
            if (t > {32'd0, ACC_CAP}) begin
                acc = ACC_CAP;
                acc_clamped = 1;
            end else begin
                acc = t[31:0];
            end
        endfunction

        function void note_byte(logic [7:0] b);
            bit digit;
            bit space;
            digit = (b >= CHAR_ZERO) && (b <= CHAR_NINE);
            space = (b == CHAR_SPACE) || ((b >= CHAR_TAB) && (b <= CHAR_CR));

            if (b == CHAR_LF && prev_cr) begin
                if (first_ends || line_pos == 4'd1) begin
                    if (found == FOUND_NONE)
                        expected_results.push_back({6'd0, 1'b0, lines, 1'b0, 1'b0, default_len});
                    else
                        expected_results.push_back({6'd0, found_clamped, lines, 1'b1, found});
                    clear_message();
                    return;
                end
                if (!on_status) begin
                    if (lines < HEADER_CAP) lines++;
                    if (name_match) begin
                        if (negative) begin
                            found = acc_clamped ? ACC_CAP : (32'd0 - acc);
                            found_clamped = acc_clamped;
                        end else if (acc > POS_MAX) begin
                            found = POS_MAX;
                            found_clamped = 1;
                        end else begin
                            found = acc;
                            found_clamped = 0;
                        end
                    end
                end
                on_status = 0;
                clear_line();
                prev_cr = 0;
                return;
            end

            if (b == CHAR_COLON && !colon_seen) begin
                if (line_pos == 4'd0) first_ends = 1;
                if (line_pos != NAME_LEN) name_match = 0;
                colon_seen = 1;
            end else if (!colon_seen) begin
                if (line_pos < NAME_LEN) begin
                    if (b != CL_NAME[8*(13 - line_pos) +: 8]) name_match = 0;
                end else if (!(line_pos == NAME_LEN && b == CHAR_CR)) begin
                    name_match = 0;
                end
            end else begin
                case (num_phase)
                    PH_SKIP: begin
                        if (!space) begin
                            if (b == CHAR_PLUS) begin
                                num_phase = PH_SIGN;
                            end else if (b == CHAR_MINUS) begin
                                negative = 1;
                                num_phase = PH_SIGN;
                            end else if (digit) begin
                                add_digit(b - CHAR_ZERO);
                                num_phase = PH_DIGITS;
                            end else begin
                                num_phase = PH_DONE;
                            end
                        end
                    end
                    PH_SIGN, PH_DIGITS: begin
                        if (digit) begin
                            add_digit(b - CHAR_ZERO);
                            num_phase = PH_DIGITS;
                        end else begin
                            num_phase = PH_DONE;
                        end
                    end
                    default: ;
                endcase
            end

            if (line_pos < LINE_POS_MAX) line_pos++;
            prev_cr = (b == CHAR_CR);
        endfunction

        function void check_result(logic [47:0] got);
            logic [47:0] want;
            if (expected_results.size() == 0) begin
                $display("%0t: result item expected none actual %h", $time, got);
                errors++;
                return;
            end
            want = expected_results.pop_front();
            if (got[31:0] !== want[31:0]) begin
                $display("%0t: reported_length expected %0d actual %0d",
                         $time, $signed(want[31:0]), $signed(got[31:0]));
                errors++;
            end
            if (got[32] !== want[32]) begin
                $display("%0t: length_found expected %b actual %b", $time, want[32], got[32]);
                errors++;
            end
            if (got[40:33] !== want[40:33]) begin
                $display("%0t: header_count expected %0d actual %0d",
                         $time, want[40:33], got[40:33]);
                errors++;
            end
            if (got[41] !== want[41]) begin
                $display("%0t: value_saturated expected %b actual %b", $time, want[41], got[41]);
                errors++;
            end
            if (got[47:42] !== want[47:42]) begin
                $display("%0t: padding expected %h actual %h", $time, want[47:42], got[47:42]);
                errors++;
            end
        endfunction
    endclass

    length_scoreboard sb = new();

    http_header_content_length_parser #(
        .MAX_HEADERS(MAX_HEADERS)
    ) uut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_wen    (i_cfg_wen),
        .i_cfg_wdata  (i_cfg_wdata),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata (s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata (m_axis_tdata)
    );

    always #2 i_clk = ~i_clk;

    task automatic add_byte(input logic [7:0] b);
        msg_bytes.push_back(b);
    endtask

    task automatic add_text(input string s);
        for (int i = 0; i < s.len(); i++) msg_bytes.push_back(s[i]);
    endtask

    task automatic add_line(input string s);
        add_text(s);
        add_byte(CHAR_CR);
        add_byte(CHAR_LF);
    endtask

    // drives the collected bytes, one item per handshake
    task automatic send_msg();
        logic [7:0] b;
        while (msg_bytes.size() != 0) begin
            b = msg_bytes.pop_front();
            while ($urandom_range(99) < send_idle_pct) begin
                s_axis_tvalid <= 1'b0;
                @(posedge i_clk);
            end
            s_axis_tvalid <= 1'b1;
            s_axis_tdata <= b;
            @(posedge i_clk);
            while (!s_axis_tready) @(posedge i_clk);
            sb.note_byte(b);
        end
        s_axis_tvalid <= 1'b0;
    endtask

    task automatic wait_drained();
        while (sb.expected_results.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_default(input logic [30:0] v);
        i_cfg_wen <= 1'b1;
        i_cfg_wdata <= v;
        @(posedge i_clk);
        i_cfg_wen <= 1'b0;
        sb.default_len = v;
    endtask

    // one head (status line, up to six header lines, an ending line) or a broken fragment
    task automatic gen_random_head();
        int    n_hdr;
        string s;
        logic [31:0] v;
        if ($urandom_range(9) == 0) begin
            // broken fragment, state carries into the next head
            repeat ($urandom_range(1, 20)) add_byte(8'($urandom_range(255)));
            return;
        end
        if ($urandom_range(9) == 0) begin
            repeat ($urandom_range(0, 8)) add_byte(8'($urandom_range(255)));
            add_line("");
        end else begin
            add_line("HTTP/1.1 200 OK");
        end
        n_hdr = $urandom_range(0, 6);
        repeat (n_hdr) begin
            case ($urandom_range(9))
                0, 1, 2, 3: begin
                    add_text("Content-Length:");
                    repeat ($urandom_range(0, 2))
                        add_byte($urandom_range(1) ? CHAR_SPACE : CHAR_TAB);
                    case ($urandom_range(3))
                        0: add_byte(CHAR_PLUS);
                        1: add_byte(CHAR_MINUS);
                        default: ;
                    endcase
                    case ($urandom_range(2))
                        0: add_text($sformatf("%0d", $urandom_range(0, 99999)));
                        1: begin
                            v = $urandom;
                            add_text($sformatf("%0d", v));
                        end
                        default: repeat ($urandom_range(1, 13))
                            add_byte(8'(CHAR_ZERO + $urandom_range(9)));
                    endcase
                    if ($urandom_range(3) == 0) add_text(" x9");
                    add_line("");
                end
                4: add_line("Content-Length: -1");
                5: begin
                    s = "Content-Length";
                    s[$urandom_range(13)] = 8'($urandom_range(32, 126));
                    add_text(s);
                    add_line(": 77");
                end
                6: begin
                    if ($urandom_range(1))
                        add_line("Content-Length");
                    else
                        add_line("Content-Length x");
                end
                7, 8: begin
                    repeat ($urandom_range(1, 20)) add_byte(8'($urandom_range(97, 122)));
                    add_text(": ");
                    repeat ($urandom_range(0, 6)) add_byte(8'($urandom_range(33, 126)));
                    add_line("");
                end
                default: begin
                    repeat ($urandom_range(1, 18)) add_byte(8'($urandom_range(255)));
                    add_line("");
                end
            endcase
        end
        if ($urandom_range(9) == 0) begin
            add_byte(CHAR_COLON);
            add_line("x");
        end else begin
            add_line("");
        end
    endtask

    // long receiver hold-off, counted here while the sender keeps going
    initial begin
        wait (hold_go);
        @(posedge i_clk);
        hold_off <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge i_clk);
        hold_off <= 1'b0;
    end

    initial begin
        forever begin
            @(posedge i_clk);
            if (m_axis_tvalid && m_axis_tready) sb.check_result(m_axis_tdata);
            if (hold_off)
                m_axis_tready <= 1'b0;
            else
                m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    initial begin
        #2_000_000;
        $display("Mismatches found");
        $finish;
    end

    initial begin
        int sent;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        for (int p = 0; p < 4; p++) begin
            case (p)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 62; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 62; end
                default: begin send_idle_pct = 18; recv_stall_pct = 18; end
            endcase
            if (p != 0) begin
                wait_drained();
                case (p)
                    1: write_default(31'd0);
                    2: write_default(31'h7FFF_FFFF);
                    default: write_default(31'($urandom));
                endcase
            end

            if (p == 0) begin
                // receiver holds off while the directed bytes keep coming
                hold_go = 1'b1;
                // empty status line, and colon-first status line
                add_line("");
                add_byte(CHAR_COLON);
                add_line("");
                add_line("HTTP/1.1 200 OK");
                add_line("Content-Length: 42");
                add_line("");
                // positive overflow after a maximal value
                add_line("H");
                add_line("Content-Length:\t+2147483647");
                add_line("Content-Length: 2147483648");
                add_line("");
                add_line("H");
                add_line("Content-Length: -2147483648");
                add_line("");
                add_line("H");
                add_line("Content-Length: -99999999999");
                add_line("");
                add_line("H");
                add_line("Content-Length: 0000000000004294967296");
                add_line("");
                // minus one hides the earlier value
                add_line("H");
                add_line("Content-Length: 7");
                add_line("Content-Length: -1");
                add_line("");
                // name without colon decodes as zero
                add_line("H");
                add_line("Content-Length");
                add_line("");
                add_line("H");
                add_line("content-length: 5");
                add_line("Content-Lengthx: 6");
                add_line("Content-Lengt: 7");
                add_line("Content-Length: -");
                add_line("");
                // lone lf and cr inside the value, colon line ends the head
                add_line("H");
                add_text("Content-Length:\n");
                add_byte(CHAR_CR);
                add_line(" 12x3");
                add_line(":end");
                // zero byte and all-ones byte
                add_line("H");
                add_text("Content-Length: ");
                add_byte(8'h00);
                add_line("12");
                add_byte(8'h00);
                add_byte(8'hFF);
                add_line(":");
                add_line("");
                // cr cr lf still ends the line
                add_line("H");
                add_text("Content-Length: 5");
                add_byte(CHAR_CR);
                add_line("");
                add_line("");
                send_msg();

                // sender waits for every result before going on
                wait_drained();

                // header count saturation
                add_line("HTTP/1.1 200 OK");
                repeat (MAX_HEADERS + 2) add_line("a");
                add_line("Content-Length: 5");
                add_line("");
                send_msg();
            end else begin
                sent = 0;
                while (sent < PHASE_BYTES) begin
                    gen_random_head();
                    sent += msg_bytes.size();
                    send_msg();
                end
            end
            add_line("");
            add_line("");
            send_msg();
        end

        wait_drained();
        if (sb.errors == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule

// ----- files.f -----
rtl/hcl_pkg.sv
rtl/hcl_value_decoder.sv
rtl/hcl_commit.sv
rtl/http_header_content_length_parser.sv
sim/tb_http_header_content_length_parser.sv
